// File: rtl/positional_list_engine_macros.svh
// Assertion macros shared by the positional list engine modules.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("positional list engine: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("positional list engine: next-cycle check failed");

`endif

// File: rtl/ple_pkg.sv
// Package with the item types, codes and control structs of the positional list engine.
package ple_pkg;

   localparam int unsigned DEFAULT_CAPACITY = 16;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_FIND   = 3'd4;
   localparam logic [2:0] CMD_LENGTH = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic [7:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [10:0]        found_position;
      logic [10:0]        list_length;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       walk_load;
      logic       rd_en;
      logic       place;
      logic       respond;
      logic       count_clr;
      logic       count_inc;
      logic       count_dec;
      logic [1:0] status;
   } ctrl_type;

   typedef struct packed {
      logic [2:0] op;
      logic       pos_ok_ins;
      logic       pos_ok_acc;
      logic       full;
      logic       empty;
      logic       no_shift;
      logic       walk_last;
      logic       hit;
   } stat_type;

endpackage

// File: rtl/ple_controller.sv
// Controller state machine that sequences each command of the positional list engine.
module ple_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output ple_pkg::ctrl_type  ctrl,
   input  ple_pkg::stat_type  stat
);
   import ple_pkg::*;

   `include "positional_list_engine_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_DRAIN,
      S_PLACE,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               CMD_CLEAR: begin
                  ctrl.respond   = 1'b1;
                  ctrl.count_clr = 1'b1;
                  state_in       = S_IDLE;
               end
               CMD_LENGTH: begin
                  ctrl.respond = 1'b1;
                  state_in     = S_IDLE;
               end
               CMD_INSERT: begin
                  if (!stat.pos_ok_ins) begin
                     ctrl.respond = 1'b1;
                     ctrl.status  = ST_MISS;
                     state_in     = S_IDLE;
                  end else if (stat.full) begin
                     ctrl.respond = 1'b1;
                     ctrl.status  = ST_FULL;
                     state_in     = S_IDLE;
                  end else if (stat.no_shift) begin
                     state_in = S_PLACE;
                  end else begin
                     ctrl.walk_load = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               CMD_DELETE, CMD_READ: begin
                  if (!stat.pos_ok_acc) begin
                     ctrl.respond = 1'b1;
                     ctrl.status  = ST_MISS;
                     state_in     = S_IDLE;
                  end else begin
                     ctrl.walk_load = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               CMD_FIND: begin
                  if (stat.empty) begin
                     ctrl.respond = 1'b1;
                     ctrl.status  = ST_MISS;
                     state_in     = S_IDLE;
                  end else begin
                     ctrl.walk_load = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               default: begin
                  ctrl.respond = 1'b1;
                  ctrl.status  = ST_MISS;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_WALK: begin
            ctrl.rd_en = 1'b1;
            if (stat.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (stat.op == CMD_INSERT) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PLACE: begin
            ctrl.place     = 1'b1;
            ctrl.count_inc = 1'b1;
            ctrl.respond   = 1'b1;
            state_in       = S_IDLE;
         end
         S_DONE: begin
            ctrl.respond = 1'b1;
            state_in     = S_IDLE;
            if (stat.op == CMD_DELETE) begin
               ctrl.count_dec = 1'b1;
            end
            if (stat.op == CMD_FIND && !stat.hit) begin
               ctrl.status = ST_MISS;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= ctrl.respond;
      end
   end

   `PLE_ASSERT_NEXT(a_single_strobe, rsp_valid_ff, !rsp_valid_ff)
   `PLE_ASSERT_NEXT(a_accept_busy, ctrl.load, busy)
   `PLE_ASSERT_NEXT(a_respond_idle, ctrl.respond, state_ff == S_IDLE && rsp_valid_ff)

endmodule

// File: rtl/ple_datapath.sv
// Datapath with the element memory, walk pointer, count and result register of the list engine.
module ple_datapath #(
   parameter int unsigned CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  ple_pkg::req_type   req_item,
   input  ple_pkg::ctrl_type  ctrl,
   output ple_pkg::stat_type  stat,
   output ple_pkg::rsp_type   rsp_item
);
   import ple_pkg::*;

   `include "positional_list_engine_macros.svh"

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

   logic signed [31:0] mem [CAPACITY];

   req_type            req_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [IDX_W-1:0]   ptr_ff;
   logic [IDX_W-1:0]   end_ff;
   logic               up_ff;
   logic               dv_ff;
   logic [IDX_W-1:0]   addr_d_ff;
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] elem_ff;
   logic [10:0]        found_ff;
   logic               hit_ff;
   rsp_type            rsp_ff;

   logic [CMP_W-1:0]   pos_c;
   logic [CMP_W-1:0]   cnt_c;
   logic [IDX_W-1:0]   pos_idx;
   logic [IDX_W-1:0]   last_idx;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] wr_data;

   assign pos_c    = CMP_W'(req_ff.position);
   assign cnt_c    = CMP_W'(count_ff);
   assign pos_idx  = IDX_W'(pos_c - CMP_W'(1));
   assign last_idx = IDX_W'(cnt_c - CMP_W'(1));

   always_comb begin
      stat.op         = req_ff.command;
      stat.pos_ok_ins = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
      stat.pos_ok_acc = (pos_c != '0) && (pos_c <= cnt_c);
      stat.full       = (count_ff == CNT_W'(CAPACITY));
      stat.empty      = (count_ff == '0);
      stat.no_shift   = (pos_c == cnt_c + CMP_W'(1));
      stat.walk_last  = (ptr_ff == end_ff);
      stat.hit        = hit_ff;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_idx;
      wr_data = req_ff.value;
      if (ctrl.place) begin
         wr_en = 1'b1;
      end else if (dv_ff && req_ff.command == CMD_INSERT) begin
         wr_en   = 1'b1;
         wr_addr = addr_d_ff + IDX_W'(1);
         wr_data = rd_data_ff;
      end else if (dv_ff && req_ff.command == CMD_DELETE && addr_d_ff != pos_idx) begin
         wr_en   = 1'b1;
         wr_addr = addr_d_ff - IDX_W'(1);
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.count_clr) begin
         count_in = '0;
      end else if (ctrl.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dv_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         dv_ff    <= ctrl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      addr_d_ff <= ptr_ff;
      if (ctrl.load) begin
         req_ff   <= req_item;
         elem_ff  <= '0;
         found_ff <= '0;
         hit_ff   <= 1'b0;
      end else if (dv_ff) begin
         if (req_ff.command == CMD_READ ||
             (req_ff.command == CMD_DELETE && addr_d_ff == pos_idx)) begin
            elem_ff <= rd_data_ff;
         end
         if (req_ff.command == CMD_FIND && !hit_ff && rd_data_ff == req_ff.value) begin
            hit_ff   <= 1'b1;
            found_ff <= 11'(addr_d_ff) + 11'd1;
         end
      end
      if (ctrl.walk_load) begin
         case (req_ff.command)
            CMD_INSERT: begin
               ptr_ff <= last_idx;
               end_ff <= pos_idx;
               up_ff  <= 1'b0;
            end
            CMD_DELETE: begin
               ptr_ff <= pos_idx;
               end_ff <= last_idx;
               up_ff  <= 1'b1;
            end
            CMD_READ: begin
               ptr_ff <= pos_idx;
               end_ff <= pos_idx;
               up_ff  <= 1'b1;
            end
            default: begin
               ptr_ff <= '0;
               end_ff <= last_idx;
               up_ff  <= 1'b1;
            end
         endcase
      end else if (ctrl.rd_en) begin
         ptr_ff <= up_ff ? ptr_ff + IDX_W'(1) : ptr_ff - IDX_W'(1);
      end
      if (ctrl.respond) begin
         rsp_ff.status         <= ctrl.status;
         rsp_ff.element        <= elem_ff;
         rsp_ff.found_position <= found_ff;
         rsp_ff.list_length    <= 11'(count_in);
      end
   end

   assign rsp_item = rsp_ff;

   `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `PLE_ASSERT_NOW(a_one_write, ctrl.place, !dv_ff && !ctrl.rd_en)
   `PLE_ASSERT_NEXT(a_hit_holds, hit_ff && !ctrl.load, hit_ff && found_ff != '0)

endmodule

// File: rtl/positional_list_engine.sv
// Top level of the positional list engine: controller and datapath around one element memory.
//
//   Channel   Ports                   Handshake
//   input     req_item                accepted when start is high and busy is low
//   result    rsp_item, rsp_valid     one-cycle strobe, always taken
//
// Clear, length and rejected commands respond straight from the decode state.
// Read, delete and find walk k entries of the memory before they respond
// (1 for read, length - position + 1 for delete, length for find).
// Insert at the tail goes straight from decode to place; otherwise it first walks and shifts
// length - position + 1 entries, since the memory port moves one entry per cycle; one item is in work at a time.
// Reset is synchronous and empties the list; memory contents are not cleared.
module positional_list_engine #(
   parameter int unsigned CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ple_pkg::req_type  req_item,
   output logic              rsp_valid,
   output ple_pkg::rsp_type  rsp_item
);
   import ple_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   ple_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .ctrl     (ctrl),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule
